@@ hw/rtl/folc_pkg.sv @@
// Shared types, geometry limits and register codes for the flash operation
// location counter. No dependencies.
`default_nettype none

package folc_pkg;

	// Table depths per operation kind
	localparam int MAX_CHANNELS = 8;
	localparam int MAX_DIES     = 64;
	localparam int MAX_BLOCKS   = 4096;
	localparam int MAX_PAGES    = 65536;

	// Index bits per table, kind bit on top gives the memory address width
	localparam int CHAN_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int DIE_IW  = (MAX_DIES > 1)     ? $clog2(MAX_DIES)     : 1;
	localparam int BLK_IW  = (MAX_BLOCKS > 1)   ? $clog2(MAX_BLOCKS)   : 1;
	localparam int PAGE_IW = (MAX_PAGES > 1)    ? $clog2(MAX_PAGES)    : 1;
	localparam int CHAN_AW = CHAN_IW + 1;
	localparam int DIE_AW  = DIE_IW + 1;
	localparam int BLK_AW  = BLK_IW + 1;
	localparam int PAGE_AW = PAGE_IW + 1;

	// Sweep counter width for the clearing pass: widest memory address
	localparam int CLR_AW01 = (CHAN_AW > DIE_AW) ? CHAN_AW : DIE_AW;
	localparam int CLR_AW23 = (BLK_AW > PAGE_AW) ? BLK_AW : PAGE_AW;
	localparam int CLR_AW   = (CLR_AW01 > CLR_AW23) ? CLR_AW01 : CLR_AW23;

	// Counter and flat index widths
	localparam int CNT_W = 32;
	localparam int DIE_W = 14;

	// Table slots
	localparam int NUM_TBL  = 4;
	localparam int TBL_CHAN = 0;
	localparam int TBL_DIE  = 1;
	localparam int TBL_BLK  = 2;
	localparam int TBL_PAGE = 3;

	// Configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 13;
	localparam logic [CFG_IW-1:0] CFG_ENABLE = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_MASK   = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_PPC    = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_DPP    = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_PPD    = 3'd4;
	localparam logic [CFG_IW-1:0] CFG_BPP    = 3'd5;
	localparam logic [CFG_IW-1:0] CFG_PGB    = 3'd6;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic [4:0]  ppc;
		logic [4:0]  dpp;
		logic [2:0]  ppd;
		logic [12:0] bpp;
		logic [8:0]  pgb;
	} geom_t;

	typedef struct packed {
		logic [2:0]  chan;
		logic [3:0]  pkg;
		logic [3:0]  die;
		logic [1:0]  plane;
		logic [11:0] blk;
		logic [7:0]  page;
	} loc_t;

	typedef struct packed {
		logic [DIE_W-1:0] fdie;
		cnt_t             fblk;
		cnt_t             fpage;
	} flat_t;

	typedef struct packed {
		logic en;
		logic inr;
	} tbl_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/folc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module folc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/folc_index.sv @@
// Five-stage multiply pipeline forming flat die, block and page indices.
// Depends on folc_pkg.
`default_nettype none

module folc_index
	import folc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  go,
	input  wire loc_t  loc,
	input  wire geom_t geom,
	output logic       done,
	output flat_t      flat
);

	logic             v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [7:0]       t1_s1;
	logic [8:0]       t2_s1;
	logic [3:0]       die_s1;
	logic [1:0]       pl_s1, pl_s2;
	logic [11:0]      blk_s1, blk_s2, blk_s3;
	logic [7:0]       pg_s1, pg_s2, pg_s3, pg_s4;
	logic [DIE_W-1:0] fdie_s2, fdie_s3, fdie_s4, fdie_s5;
	logic [16:0]      u_s3;
	logic [14:0]      v_s3_prod;
	cnt_t             fblk_s4, fblk_s5, fpage_s5;

	// Advance the valid marker
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= go;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// Stage 1: channel and package partial products
	always_ff @(posedge clk) begin
		if (go) begin
			t1_s1  <= 8'(loc.chan) * 8'(geom.ppc);
			t2_s1  <= 9'(loc.pkg) * 9'(geom.dpp);
			die_s1 <= loc.die;
			pl_s1  <= loc.plane;
			blk_s1 <= loc.blk;
			pg_s1  <= loc.page;
		end
	end

	// Stage 2: flat die index
	always_ff @(posedge clk) begin
		fdie_s2 <= DIE_W'(t1_s1) * DIE_W'(geom.dpp) + DIE_W'(t2_s1) + DIE_W'(die_s1);
		pl_s2   <= pl_s1;
		blk_s2  <= blk_s1;
		pg_s2   <= pg_s1;
	end

	// Stage 3: die and plane partial products
	always_ff @(posedge clk) begin
		u_s3      <= 17'(fdie_s2) * 17'(geom.ppd);
		v_s3_prod <= 15'(pl_s2) * 15'(geom.bpp);
		fdie_s3   <= fdie_s2;
		blk_s3    <= blk_s2;
		pg_s3     <= pg_s2;
	end

	// Stage 4: flat block index
	always_ff @(posedge clk) begin
		fblk_s4 <= CNT_W'(u_s3) * CNT_W'(geom.bpp) + CNT_W'(v_s3_prod) + CNT_W'(blk_s3);
		fdie_s4 <= fdie_s3;
		pg_s4   <= pg_s3;
	end

	// Stage 5: flat page index, wrapping at 32 bits
	always_ff @(posedge clk) begin
		fpage_s5 <= fblk_s4 * CNT_W'(geom.pgb) + CNT_W'(pg_s4);
		fblk_s5  <= fblk_s4;
		fdie_s5  <= fdie_s4;
	end

	assign done       = v_s5;
	assign flat.fdie  = fdie_s5;
	assign flat.fblk  = fblk_s5;
	assign flat.fpage = fpage_s5;

endmodule

`default_nettype wire

@@ hw/rtl/folc_update.sv @@
// Counter modify logic for the four tables: increment, gate and flag.
// Depends on folc_pkg.
`default_nettype none

module folc_update
	import folc_pkg::*;
(
	input  wire logic                    bump,
	input  wire tbl_ctl_t [NUM_TBL-1:0]  ctl,
	input  wire cnt_t     [NUM_TBL-1:0]  rd,
	output logic          [NUM_TBL-1:0]  wr_en,
	output cnt_t          [NUM_TBL-1:0]  wr_data,
	output cnt_t          [NUM_TBL-1:0]  total,
	output logic                         oor
);

	// Bump enabled in-range counters, zero the rest
	always_comb begin
		oor = 1'b0;
		for (int i = 0; i < NUM_TBL; i++) begin
			wr_en[i]   = ctl[i].en & ctl[i].inr & bump;
			wr_data[i] = rd[i] + CNT_W'(1);
			if (ctl[i].en && ctl[i].inr) begin
				total[i] = bump ? wr_data[i] : rd[i];
			end else begin
				total[i] = '0;
			end
			if (ctl[i].en && !ctl[i].inr) begin
				oor = 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/flash_op_location_counter_core.sv @@
// Top level of the flash operation location counter: sequencer, registers,
// counter memories. Depends on folc_pkg, folc_ram, folc_index, folc_update.
//
//   channel  handshake            payload
//   item     start / busy         func, op_kind, chan_addr .. page_addr
//   result   done (1-cycle pulse) flat_block_index, *_total, out_of_range
//   config   cfg_wr_en            cfg_index, cfg_wdata
//
// An item occupies the block from the accepting edge until done pulses, and the
// next start is taken in the cycle in which done is high. The item passes through
// the multiply chain of the index unit, the counter memory read, and the
// write-back that also loads the result.
// After reset the counter memories are cleared one entry a cycle over all 2^17 =
// 131072 addresses, with busy held high. The result side cannot stall.
`default_nettype none

module flash_op_location_counter_core
	import folc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              func,
	input  wire logic              op_kind,
	input  wire logic [2:0]        chan_addr,
	input  wire logic [3:0]        pkg_addr,
	input  wire logic [3:0]        die_addr,
	input  wire logic [1:0]        plane_addr,
	input  wire logic [11:0]       blk_addr,
	input  wire logic [7:0]        page_addr,
	input  wire logic              cfg_wr_en,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_wdata,
	output logic                   done,
	output logic [31:0]            flat_block_index,
	output logic [31:0]            chan_total,
	output logic [31:0]            die_total,
	output logic [31:0]            block_total,
	output logic [31:0]            page_total,
	output logic                   out_of_range
);

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_INDEX  = 2'd2;
	localparam logic [1:0] ST_UPDATE = 2'd3;

	logic [1:0]        state_q;
	logic [CLR_AW-1:0] clr_q;
	logic              done_q;
	logic              func_q, kind_q;
	logic [2:0]        chan_q;
	logic              enable_q;
	logic [3:0]        mask_q;
	geom_t             geom_q;
	tbl_ctl_t [NUM_TBL-1:0] ctl_q;
	tbl_ctl_t [NUM_TBL-1:0] ctl_d;
	cnt_t              fblk_q;
	logic [CHAN_AW-1:0] chan_ra, chan_ra_q, chan_wa;
	logic [DIE_AW-1:0]  die_ra,  die_ra_q,  die_wa;
	logic [BLK_AW-1:0]  blk_ra,  blk_ra_q,  blk_wa;
	logic [PAGE_AW-1:0] page_ra, page_ra_q, page_wa;
	logic              accept, clearing, updating;
	loc_t              loc;
	logic              idx_done;
	flat_t             flat;
	cnt_t [NUM_TBL-1:0] idx32;
	cnt_t [NUM_TBL-1:0] rd;
	logic [NUM_TBL-1:0] wr_en;
	cnt_t [NUM_TBL-1:0] wr_data;
	cnt_t [NUM_TBL-1:0] total;
	logic              oor;
	logic [NUM_TBL-1:0] we;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start & ~busy;
	assign clearing = (state_q == ST_CLEAR);
	assign updating = (state_q == ST_UPDATE);
	assign done     = done_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			mask_q     <= 4'd0;
			geom_q.ppc <= 5'd1;
			geom_q.dpp <= 5'd1;
			geom_q.ppd <= 3'd1;
			geom_q.bpp <= 13'd1;
			geom_q.pgb <= 9'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_ENABLE: enable_q   <= cfg_wdata[0];
				CFG_MASK:   mask_q     <= cfg_wdata[3:0];
				CFG_PPC:    geom_q.ppc <= cfg_wdata[4:0];
				CFG_DPP:    geom_q.dpp <= cfg_wdata[4:0];
				CFG_PPD:    geom_q.ppd <= cfg_wdata[2:0];
				CFG_BPP:    geom_q.bpp <= cfg_wdata[12:0];
				CFG_PGB:    geom_q.pgb <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	// Index unit
	assign loc.chan  = chan_addr;
	assign loc.pkg   = pkg_addr;
	assign loc.die   = die_addr;
	assign loc.plane = plane_addr;
	assign loc.blk   = blk_addr;
	assign loc.page  = page_addr;

	folc_index u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (accept),
		.loc    (loc),
		.geom   (geom_q),
		.done   (idx_done),
		.flat   (flat)
	);

	// Form table indices, range flags and read addresses
	always_comb begin
		idx32[TBL_CHAN] = CNT_W'(chan_q);
		idx32[TBL_DIE]  = CNT_W'(flat.fdie);
		idx32[TBL_BLK]  = flat.fblk;
		idx32[TBL_PAGE] = flat.fpage;
		ctl_d[TBL_CHAN].inr = idx32[TBL_CHAN] < CNT_W'(MAX_CHANNELS);
		ctl_d[TBL_DIE].inr  = idx32[TBL_DIE]  < CNT_W'(MAX_DIES);
		ctl_d[TBL_BLK].inr  = idx32[TBL_BLK]  < CNT_W'(MAX_BLOCKS);
		ctl_d[TBL_PAGE].inr = idx32[TBL_PAGE] < CNT_W'(MAX_PAGES);
		for (int i = 0; i < NUM_TBL; i++) begin
			ctl_d[i].en = enable_q & mask_q[i];
		end
		chan_ra = {kind_q, idx32[TBL_CHAN][CHAN_IW-1:0]};
		die_ra  = {kind_q, idx32[TBL_DIE][DIE_IW-1:0]};
		blk_ra  = {kind_q, idx32[TBL_BLK][BLK_IW-1:0]};
		page_ra = {kind_q, idx32[TBL_PAGE][PAGE_IW-1:0]};
	end

	// Sequence: clear sweep, then index, read, write back per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_AW'(1);
					if (clr_q == {CLR_AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_INDEX;
					end
				end
				ST_INDEX: begin
					if (idx_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the item's function, kind and channel
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			kind_q <= op_kind;
			chan_q <= chan_addr;
		end
	end

	// Hold index results for the write-back
	always_ff @(posedge clk) begin
		if (state_q == ST_INDEX && idx_done) begin
			ctl_q     <= ctl_d;
			fblk_q    <= flat.fblk;
			chan_ra_q <= chan_ra;
			die_ra_q  <= die_ra;
			blk_ra_q  <= blk_ra;
			page_ra_q <= page_ra;
		end
	end

	folc_update u_update (
		.bump    (~func_q),
		.ctl     (ctl_q),
		.rd      (rd),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.total   (total),
		.oor     (oor)
	);

	// Drive the beat onto the result ports
	always_ff @(posedge clk) begin
		if (updating) begin
			flat_block_index <= fblk_q;
			chan_total       <= total[TBL_CHAN];
			die_total        <= total[TBL_DIE];
			block_total      <= total[TBL_BLK];
			page_total       <= total[TBL_PAGE];
			out_of_range     <= oor;
		end
	end

	// Memory write side: zero sweep or write-back
	assign chan_wa = clearing ? clr_q[CHAN_AW-1:0] : chan_ra_q;
	assign die_wa  = clearing ? clr_q[DIE_AW-1:0]  : die_ra_q;
	assign blk_wa  = clearing ? clr_q[BLK_AW-1:0]  : blk_ra_q;
	assign page_wa = clearing ? clr_q[PAGE_AW-1:0] : page_ra_q;

	always_comb begin
		for (int i = 0; i < NUM_TBL; i++) begin
			we[i] = clearing | (updating & wr_en[i]);
		end
	end

	folc_ram #(.WIDTH(CNT_W), .DEPTH(2 ** CHAN_AW)) u_chan_ram (
		.clk   (clk),
		.we    (we[TBL_CHAN]),
		.waddr (chan_wa),
		.wdata (clearing ? '0 : wr_data[TBL_CHAN]),
		.raddr (chan_ra),
		.rdata (rd[TBL_CHAN])
	);

	folc_ram #(.WIDTH(CNT_W), .DEPTH(2 ** DIE_AW)) u_die_ram (
		.clk   (clk),
		.we    (we[TBL_DIE]),
		.waddr (die_wa),
		.wdata (clearing ? '0 : wr_data[TBL_DIE]),
		.raddr (die_ra),
		.rdata (rd[TBL_DIE])
	);

	folc_ram #(.WIDTH(CNT_W), .DEPTH(2 ** BLK_AW)) u_blk_ram (
		.clk   (clk),
		.we    (we[TBL_BLK]),
		.waddr (blk_wa),
		.wdata (clearing ? '0 : wr_data[TBL_BLK]),
		.raddr (blk_ra),
		.rdata (rd[TBL_BLK])
	);

	folc_ram #(.WIDTH(CNT_W), .DEPTH(2 ** PAGE_AW)) u_page_ram (
		.clk   (clk),
		.we    (we[TBL_PAGE]),
		.waddr (page_wa),
		.wdata (clearing ? '0 : wr_data[TBL_PAGE]),
		.raddr (page_ra),
		.rdata (rd[TBL_PAGE])
	);

endmodule

`default_nettype wire

@@ sim/tb_flash_op_location_counter_core.sv @@
// Self-checking testbench for flash_op_location_counter_core: drives count and
// query beats through several geometries and checks each result against a
// built-in predictor of the counter tables. Depends on folc_pkg and the core.
`default_nettype none

module tb_flash_op_location_counter_core;
	import folc_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE       = 10;
	localparam int PHASES       = 12;
	localparam int PHASE_OPS    = 96;

	// Index outside the register list, written to check that it is ignored
	localparam logic [CFG_IW-1:0] CFG_UNUSED = 3'd7;

	typedef enum bit {FN_COUNT = 1'b0, FN_QUERY = 1'b1} fn_e;
	typedef enum bit {OP_READ = 1'b0, OP_WRITE = 1'b1} kind_e;

	typedef struct packed {
		fn_e         func;
		kind_e       kind;
		bit [2:0]    chan;
		bit [3:0]    pkg;
		bit [3:0]    die;
		bit [1:0]    plane;
		bit [11:0]   blk;
		bit [7:0]    page;
	} flash_op_t;

	typedef struct packed {
		bit                is_cfg;
		bit [CFG_IW-1:0]   idx;
		bit [CFG_DW-1:0]   val;
		flash_op_t         op;
	} stim_t;

	typedef struct packed {
		bit [31:0] fblk;
		bit [31:0] chan;
		bit [31:0] die;
		bit [31:0] blk;
		bit [31:0] page;
		bit        oor;
	} totals_t;

	// DUT ports
	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              func = 1'b0;
	logic              op_kind = 1'b0;
	logic [2:0]        chan_addr = '0;
	logic [3:0]        pkg_addr = '0;
	logic [3:0]        die_addr = '0;
	logic [1:0]        plane_addr = '0;
	logic [11:0]       blk_addr = '0;
	logic [7:0]        page_addr = '0;
	logic              cfg_wr_en = 1'b0;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_wdata = '0;
	logic              done;
	logic [31:0]       flat_block_index;
	logic [31:0]       chan_total;
	logic [31:0]       die_total;
	logic [31:0]       block_total;
	logic [31:0]       page_total;
	logic              out_of_range;

	flash_op_location_counter_core u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.func(func), .op_kind(op_kind), .chan_addr(chan_addr), .pkg_addr(pkg_addr),
		.die_addr(die_addr), .plane_addr(plane_addr), .blk_addr(blk_addr),
		.page_addr(page_addr), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .done(done), .flat_block_index(flat_block_index),
		.chan_total(chan_total), .die_total(die_total), .block_total(block_total),
		.page_total(page_total), .out_of_range(out_of_range)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the registers and counter tables
	bit [31:0] m_enable, m_mask, m_ppc, m_dpp, m_ppd, m_bpp, m_pgb;
	bit [31:0] chan_cnt [2][MAX_CHANNELS];
	bit [31:0] die_cnt  [2][MAX_DIES];
	bit [31:0] blk_cnt  [2][MAX_BLOCKS];
	bit [31:0] page_cnt [2][MAX_PAGES];

	stim_t     flash_ops_q[$];
	totals_t   expected_totals_q[$];
	flash_op_t cur_op;
	stim_t     next_stim;
	totals_t   want;
	int        burst_left, gap_left, quiet;
	int        n_errors, n_items, n_queries, n_oor, n_cfg, cycles;

	// Stimulus-side view of the geometry, used to aim addresses
	int        p_ppc, p_dpp, p_ppd, p_bpp, p_pgb;
	flash_op_t last_op;

	function automatic void write_register(bit [CFG_IW-1:0] idx, bit [CFG_DW-1:0] val);
		case (idx)
			CFG_ENABLE: m_enable = val & 32'h1;
			CFG_MASK:   m_mask   = val & 32'hF;
			CFG_PPC:    m_ppc    = val & 32'h1F;
			CFG_DPP:    m_dpp    = val & 32'h1F;
			CFG_PPD:    m_ppd    = val & 32'h7;
			CFG_BPP:    m_bpp    = val & 32'h1FFF;
			CFG_PGB:    m_pgb    = val & 32'h1FF;
			default: ;
		endcase
	endfunction

	// Form the flat indices, bump the enabled tables and return the counts
	function automatic totals_t count_flash_op(flash_op_t o);
		bit [31:0] fdie, fblk, fpage;
		bit        on, bump;
		int        k;
		totals_t   r;
		on   = (m_enable != 0);
		bump = (o.func == FN_COUNT);
		k    = int'(o.kind);
		fdie  = o.chan * m_ppc * m_dpp + o.pkg * m_dpp + o.die;
		fblk  = fdie * m_ppd * m_bpp + o.plane * m_bpp + o.blk;
		fpage = fblk * m_pgb + o.page;
		r = '0;
		r.fblk = fblk;
		if (on && m_mask[TBL_CHAN]) begin
			if (o.chan >= MAX_CHANNELS) begin
				r.oor = 1'b1;
			end else begin
				if (bump) chan_cnt[k][o.chan] = chan_cnt[k][o.chan] + 1;
				r.chan = chan_cnt[k][o.chan];
			end
		end
		if (on && m_mask[TBL_DIE]) begin
			if (fdie >= MAX_DIES) begin
				r.oor = 1'b1;
			end else begin
				if (bump) die_cnt[k][fdie[DIE_IW-1:0]] = die_cnt[k][fdie[DIE_IW-1:0]] + 1;
				r.die = die_cnt[k][fdie[DIE_IW-1:0]];
			end
		end
		if (on && m_mask[TBL_BLK]) begin
			if (fblk >= MAX_BLOCKS) begin
				r.oor = 1'b1;
			end else begin
				if (bump) blk_cnt[k][fblk[BLK_IW-1:0]] = blk_cnt[k][fblk[BLK_IW-1:0]] + 1;
				r.blk = blk_cnt[k][fblk[BLK_IW-1:0]];
			end
		end
		if (on && m_mask[TBL_PAGE]) begin
			if (fpage >= MAX_PAGES) begin
				r.oor = 1'b1;
			end else begin
				if (bump) page_cnt[k][fpage[PAGE_IW-1:0]] = page_cnt[k][fpage[PAGE_IW-1:0]] + 1;
				r.page = page_cnt[k][fpage[PAGE_IW-1:0]];
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, bit [31:0] exp_val);
		$display("%0t: mismatch on %s: got %h, want %h", $time, what, got, exp_val);
		n_errors++;
	endtask

	// Driver: accept beats, issue register writes when idle, pace in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			cfg_wr_en  <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
			quiet      <= 0;
		end else begin
			if (start && !busy) begin
				want = count_flash_op(cur_op);
				expected_totals_q.push_back(want);
				n_items++;
				if (cur_op.func == FN_QUERY) n_queries++;
				if (want.oor) n_oor++;
			end
			if (cfg_wr_en) write_register(cfg_index, cfg_wdata);
			quiet <= ((start && !busy) || done) ? 0 : (quiet < SETTLE ? quiet + 1 : quiet);

			if (start && busy) begin
				// hold the beat until it is taken
				cfg_wr_en <= 1'b0;
			end else if (gap_left != 0) begin
				start     <= 1'b0;
				cfg_wr_en <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (flash_ops_q.size() == 0) begin
				start     <= 1'b0;
				cfg_wr_en <= 1'b0;
			end else if (flash_ops_q[0].is_cfg) begin
				start <= 1'b0;
				// write only once the block has drained and settled
				if (expected_totals_q.size() == 0 && quiet >= SETTLE && !busy) begin
					next_stim = flash_ops_q.pop_front();
					cfg_wr_en <= 1'b1;
					cfg_index <= next_stim.idx;
					cfg_wdata <= next_stim.val;
					n_cfg++;
				end else begin
					cfg_wr_en <= 1'b0;
				end
			end else begin
				next_stim = flash_ops_q.pop_front();
				cur_op     <= next_stim.op;
				func       <= next_stim.op.func;
				op_kind    <= next_stim.op.kind;
				chan_addr  <= next_stim.op.chan;
				pkg_addr   <= next_stim.op.pkg;
				die_addr   <= next_stim.op.die;
				plane_addr <= next_stim.op.plane;
				blk_addr   <= next_stim.op.blk;
				page_addr  <= next_stim.op.page;
				start      <= 1'b1;
				cfg_wr_en  <= 1'b0;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction
	totals_t got_want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_totals_q.size() == 0) begin
				report_mismatch("result with nothing pending", flat_block_index, 32'h0);
			end else begin
				got_want = expected_totals_q.pop_front();
				if (flat_block_index !== got_want.fblk)
					report_mismatch("flat_block_index", flat_block_index, got_want.fblk);
				if (chan_total !== got_want.chan)
					report_mismatch("chan_total", chan_total, got_want.chan);
				if (die_total !== got_want.die)
					report_mismatch("die_total", die_total, got_want.die);
				if (block_total !== got_want.blk)
					report_mismatch("block_total", block_total, got_want.blk);
				if (page_total !== got_want.page)
					report_mismatch("page_total", page_total, got_want.page);
				if (out_of_range !== got_want.oor)
					report_mismatch("out_of_range", {31'h0, out_of_range}, {31'h0, got_want.oor});
			end
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycles,
				expected_totals_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic push_cfg(bit [CFG_IW-1:0] idx, int val);
		stim_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.idx = idx;
		s.val = val[CFG_DW-1:0];
		flash_ops_q.push_back(s);
		case (idx)
			CFG_PPC: p_ppc = val & 'h1F;
			CFG_DPP: p_dpp = val & 'h1F;
			CFG_PPD: p_ppd = val & 'h7;
			CFG_BPP: p_bpp = val & 'h1FFF;
			CFG_PGB: p_pgb = val & 'h1FF;
			default: ;
		endcase
	endtask

	task automatic push_op(fn_e f, kind_e k, int ch, int pkg, int die, int pl, int blk, int pg);
		stim_t s;
		s = '0;
		s.op.func  = f;
		s.op.kind  = k;
		s.op.chan  = 3'(ch);
		s.op.pkg   = 4'(pkg);
		s.op.die   = 4'(die);
		s.op.plane = 2'(pl);
		s.op.blk   = 12'(blk);
		s.op.page  = 8'(pg);
		flash_ops_q.push_back(s);
		last_op = s.op;
	endtask

	// Random value below the configured count, clipped to the field range
	function automatic int pick_below(int n, int fmax);
		if (n <= 1) return 0;
		return $urandom_range(0, (n - 1 > fmax) ? fmax : n - 1);
	endfunction

	function automatic int pick_geometry(int lo_hi, int range_hi, int all_ones);
		case ($urandom_range(0, 9))
			0: return all_ones;
			1: return 0;
			2: return range_hi;
			default: return $urandom_range(1, lo_hi);
		endcase
	endfunction

	task automatic random_phase_setup();
		push_cfg(CFG_ENABLE, ($urandom_range(0, 9) == 0) ? 0 : 1);
		push_cfg(CFG_MASK, ($urandom_range(0, 9) < 6) ? 15 : $urandom_range(0, 15));
		push_cfg(CFG_PPC, pick_geometry(4, 16, 31));
		push_cfg(CFG_DPP, pick_geometry(4, 16, 31));
		push_cfg(CFG_PPD, pick_geometry(4, 4, 7));
		push_cfg(CFG_BPP, pick_geometry(64, 4096, 8191));
		push_cfg(CFG_PGB, pick_geometry(16, 256, 511));
		if ($urandom_range(0, 3) == 0) push_cfg(CFG_UNUSED, $urandom_range(0, 8191));
	endtask

	task automatic push_random_op();
		fn_e   f;
		kind_e k;
		int    sel;
		f   = ($urandom_range(0, 4) == 0) ? FN_QUERY : FN_COUNT;
		k   = kind_e'($urandom_range(0, 1));
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			// noise: any address at all
			push_op(f, k, $urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 15),
				$urandom_range(0, 3), $urandom_range(0, 4095), $urandom_range(0, 255));
		end else if (sel < 50) begin
			// revisit the last location so its counts build up
			push_op(f, k, last_op.chan, last_op.pkg, last_op.die, last_op.plane,
				last_op.blk, last_op.page);
		end else begin
			// aim inside the configured geometry
			push_op(f, k, $urandom_range(0, 7), pick_below(p_ppc, 15), pick_below(p_dpp, 15),
				pick_below(p_ppd, 3), pick_below(p_bpp, 4095), pick_below(p_pgb, 255));
		end
	endtask

	initial begin
		p_ppc = 1; p_dpp = 1; p_ppd = 1; p_bpp = 1; p_pgb = 1;
		m_enable = 0; m_mask = 0;
		m_ppc = 1; m_dpp = 1; m_ppd = 1; m_bpp = 1; m_pgb = 1;

		// reset settings: counting disabled
		push_op(FN_COUNT, OP_READ, 0, 0, 0, 0, 0, 0);
		push_op(FN_COUNT, OP_WRITE, 7, 15, 15, 3, 4095, 255);

		// small geometry, all tables on; master enable written with spare bits set
		push_cfg(CFG_ENABLE, 8191);
		push_cfg(CFG_MASK, 15);
		push_cfg(CFG_PPC, 2);
		push_cfg(CFG_DPP, 2);
		push_cfg(CFG_PPD, 2);
		push_cfg(CFG_BPP, 16);
		push_cfg(CFG_PGB, 8);
		push_cfg(CFG_UNUSED, 8191);
		push_op(FN_COUNT, OP_READ, 0, 0, 0, 0, 0, 0);
		push_op(FN_COUNT, OP_READ, 0, 0, 0, 0, 0, 0);
		push_op(FN_COUNT, OP_WRITE, 0, 0, 0, 0, 0, 0);
		push_op(FN_QUERY, OP_READ, 0, 0, 0, 0, 0, 0);
		push_op(FN_QUERY, OP_WRITE, 0, 0, 0, 0, 0, 0);
		push_op(FN_COUNT, OP_READ, 1, 1, 1, 1, 15, 7);
		push_op(FN_COUNT, OP_WRITE, 7, 15, 15, 3, 4095, 255);
		push_op(FN_QUERY, OP_WRITE, 7, 15, 15, 3, 4095, 255);

		// partial mask: channel and block tables only
		push_cfg(CFG_MASK, 5);
		push_op(FN_COUNT, OP_READ, 0, 0, 0, 0, 0, 0);
		push_op(FN_QUERY, OP_READ, 0, 0, 0, 0, 0, 0);

		// master enable off leaves every count alone
		push_cfg(CFG_ENABLE, 0);
		push_op(FN_COUNT, OP_READ, 0, 0, 0, 0, 0, 0);
		push_cfg(CFG_ENABLE, 1);
		push_cfg(CFG_MASK, 15);

		// largest geometry in range
		push_cfg(CFG_PPC, 16);
		push_cfg(CFG_DPP, 16);
		push_cfg(CFG_PPD, 4);
		push_cfg(CFG_BPP, 4096);
		push_cfg(CFG_PGB, 256);
		push_op(FN_COUNT, OP_WRITE, 0, 0, 0, 0, 0, 0);
		push_op(FN_COUNT, OP_READ, 7, 15, 15, 3, 4095, 255);
		push_op(FN_QUERY, OP_WRITE, 0, 0, 0, 0, 0, 0);

		// odd geometry: zero and all-ones register values
		push_cfg(CFG_PPC, 0);
		push_cfg(CFG_DPP, 31);
		push_cfg(CFG_PPD, 7);
		push_cfg(CFG_BPP, 8191);
		push_cfg(CFG_PGB, 511);
		push_op(FN_COUNT, OP_WRITE, 7, 15, 15, 3, 4095, 255);
		push_op(FN_COUNT, OP_READ, 5, 0, 1, 0, 3, 9);
		push_cfg(CFG_PGB, 0);
		push_op(FN_COUNT, OP_READ, 0, 0, 0, 1, 100, 200);

		// random phases, each under its own settings
		for (int ph = 0; ph < PHASES; ph++) begin
			random_phase_setup();
			repeat (PHASE_OPS) push_random_op();
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// drain, then watch for stray results
		while (flash_ops_q.size() != 0 || start || expected_totals_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("checked %0d beats (%0d queries, %0d out of range) over %0d register writes",
			n_items, n_queries, n_oor, n_cfg);
		$display("%0d mismatches in %0d cycles", n_errors, cycles);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/folc_pkg.sv
hw/rtl/folc_ram.sv
hw/rtl/folc_index.sv
hw/rtl/folc_update.sv
hw/rtl/flash_op_location_counter_core.sv
sim/tb_flash_op_location_counter_core.sv
